FILE: src/rdrf_pkg.sv
`default_nettype none

package rdrf_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_RSSI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT   = 2'd1;

  localparam logic signed [7:0] MIN_RSSI_RST = -8'sd90;
  localparam logic [31:0]       REPEAT_RST   = 32'd10000;

  localparam int SLOT_W = 5;

  typedef enum logic [2:0] {
    OUT_WEAK     = 3'd0,
    OUT_RECENT   = 3'd1,
    OUT_REFRESH  = 3'd2,
    OUT_FILLED   = 3'd3,
    OUT_REPLACED = 3'd4
  } outcome_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // input word
  typedef struct packed {
    logic [31:0]        device_hash;
    logic signed [7:0]  signal_dbm;
    logic [31:0]        now_ms;
  } obs_t;

  // result word
  typedef struct packed {
    logic              report;
    logic [2:0]        outcome;
    logic [SLOT_W-1:0] slot;
  } res_t;

  // one table entry
  typedef struct packed {
    logic [31:0] hash;
    logic [31:0] seen;
  } entry_t;

  // per-cell control
  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/rdrf_cell.sv
`default_nettype none

module rdrf_cell (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire rdrf_pkg::cell_ctrl_t ctrl,
  input  wire rdrf_pkg::entry_t    nbr,
  input  wire rdrf_pkg::entry_t    wr_data,
  output rdrf_pkg::entry_t         ent
);

  // entry register: shifts from neighbor while scanning, loads on write
  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '0;
    end else if (ctrl.shift) begin
      ent <= nbr;
    end else if (ctrl.wr) begin
      ent <= wr_data;
    end
  end

endmodule

`default_nettype wire

FILE: src/recent_device_report_filter_unit.sv
`default_nettype none

// One word at a time: it is scanned (not for a weak signal), its result is loaded once
// the output register is free, then the next word is taken. The table rotates once
// through a ring of cells past a single compare stage at cell 0, one entry per cycle.
// A waiting result sits in the output register while the next word is scanned.
// Reset (rst, synchronous, active high) empties all entries and loads register defaults.
module recent_device_report_filter_unit #(
  parameter int ENTRIES = 24
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire rdrf_pkg::obs_t                     obs,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output rdrf_pkg::res_t                          res,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [rdrf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rdrf_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int IW = $clog2(ENTRIES);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  // configuration registers
  logic signed [7:0] min_rssi;
  logic [31:0]       repeat_ms;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rssi  <= rdrf_pkg::MIN_RSSI_RST;
      repeat_ms <= rdrf_pkg::REPEAT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == rdrf_pkg::REG_MIN_RSSI) begin
        min_rssi <= $signed(cfg_data[7:0]);
      end else if (cfg_index == rdrf_pkg::REG_REPEAT) begin
        repeat_ms <= cfg_data;
      end
    end
  end

  // controller state
  rdrf_pkg::state_t state, state_next;
  logic [IW-1:0]    cnt;
  rdrf_pkg::obs_t   cur;
  logic             low_sig;

  // scan results
  logic          found;
  logic [IW-1:0] match_idx;
  logic [31:0]   match_seen;
  logic          have_empty;
  logic [IW-1:0] empty_idx;
  logic [IW-1:0] oldest_idx;
  logic [31:0]   oldest_seen;

  // ring of cells
  rdrf_pkg::entry_t ents [ENTRIES];
  rdrf_pkg::entry_t head;
  rdrf_pkg::entry_t wr_data;
  logic [IW-1:0]    wr_idx;
  logic             wr_en;
  logic             shift;
  logic [ENTRIES-1:0] wr_vec;

  assign head = ents[0];

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    localparam int NXT = (k + 1) % ENTRIES;
    rdrf_pkg::cell_ctrl_t ctrl;
    assign wr_vec[k]  = wr_en && (wr_idx == IW'(k));
    assign ctrl.shift = shift;
    assign ctrl.wr    = wr_vec[k];
    rdrf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .nbr     (ents[NXT]),
      .wr_data (wr_data),
      .ent     (ents[k])
    );
  end

  // result selection in the done state
  logic            recent;
  logic            load;
  rdrf_pkg::res_t  res_d;
  logic [IW-1:0]   sel_idx;
  logic [IW+rdrf_pkg::SLOT_W-1:0] slot_wide;

  assign recent    = (cur.now_ms - match_seen) < repeat_ms;
  assign slot_wide = {{rdrf_pkg::SLOT_W{1'b0}}, sel_idx};

  always_comb begin
    sel_idx = oldest_idx;
    res_d   = '0;
    if (low_sig) begin
      sel_idx       = '0;
      res_d.report  = 1'b0;
      res_d.outcome = rdrf_pkg::OUT_WEAK;
    end else if (found) begin
      sel_idx       = match_idx;
      res_d.report  = !recent;
      res_d.outcome = recent ? rdrf_pkg::OUT_RECENT : rdrf_pkg::OUT_REFRESH;
    end else if (have_empty) begin
      sel_idx       = empty_idx;
      res_d.report  = 1'b1;
      res_d.outcome = rdrf_pkg::OUT_FILLED;
    end else begin
      sel_idx       = oldest_idx;
      res_d.report  = 1'b1;
      res_d.outcome = rdrf_pkg::OUT_REPLACED;
    end
    res_d.slot = slot_wide[rdrf_pkg::SLOT_W-1:0];
  end

  assign wr_idx       = sel_idx;
  assign wr_data.hash = cur.device_hash;
  assign wr_data.seen = cur.now_ms;

  // next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    shift      = 1'b0;
    load       = 1'b0;
    wr_en      = 1'b0;
    case (state)
      rdrf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ($signed(obs.signal_dbm) < min_rssi) ? rdrf_pkg::ST_DONE
                                                            : rdrf_pkg::ST_SCAN;
        end
      end
      rdrf_pkg::ST_SCAN: begin
        shift = 1'b1;
        if (cnt == LAST) begin
          state_next = rdrf_pkg::ST_DONE;
        end
      end
      rdrf_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          load       = 1'b1;
          wr_en      = !low_sig && !(found && recent);
          state_next = rdrf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rdrf_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdrf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture word, step counter and scan trackers
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt        <= '0;
      low_sig    <= 1'b0;
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else if (state == rdrf_pkg::ST_IDLE && in_valid) begin
      cur        <= obs;
      low_sig    <= $signed(obs.signal_dbm) < min_rssi;
      cnt        <= '0;
      found      <= 1'b0;
      have_empty <= 1'b0;
    end else if (shift) begin
      cnt <= (cnt == LAST) ? '0 : cnt + 1'b1;
      if (!found && head.hash == cur.device_hash) begin
        found      <= 1'b1;
        match_idx  <= cnt;
        match_seen <= head.seen;
      end
      if (!have_empty && head.hash == 32'd0) begin
        have_empty <= 1'b1;
        empty_idx  <= cnt;
      end
      if (cnt == '0 || head.seen < oldest_seen) begin
        oldest_idx  <= cnt;
        oldest_seen <= head.seen;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_d;
    end
  end

`ifndef SYNTHESIS
  a_scan_ends: assert property (@(posedge clk) disable iff (rst)
    (state == rdrf_pkg::ST_SCAN && cnt == LAST) |=> state == rdrf_pkg::ST_DONE)
    else $error("scan did not end after a full rotation");

  a_wr_done: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> (state == rdrf_pkg::ST_DONE && !shift))
    else $error("table write outside done state");

  a_wr_one: assert property (@(posedge clk) disable iff (rst)
    $onehot0(wr_vec))
    else $error("more than one cell written");

  a_report: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (res.report == (res.outcome == rdrf_pkg::OUT_REFRESH ||
                                  res.outcome == rdrf_pkg::OUT_FILLED ||
                                  res.outcome == rdrf_pkg::OUT_REPLACED)))
    else $error("report flag disagrees with outcome");
`endif

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int ENTRIES = 24;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = ENTRIES + 8;
  localparam int MAX_SHOWN = 10;
  localparam int POOL_SIZE = 32;

  // register indexes the block does not decode
  localparam logic [rdrf_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [rdrf_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  rdrf_pkg::obs_t                  obs = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  rdrf_pkg::res_t                  res;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [rdrf_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [rdrf_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the device table and registers
  logic [31:0]       tab_hash [ENTRIES];
  logic [31:0]       tab_seen [ENTRIES];
  logic signed [7:0] rssi_floor;
  logic [31:0]       repeat_ms;

  rdrf_pkg::res_t expected_res [$];
  int             mismatches = 0;
  int             cycles = 0;
  int             send_idle_pct = 0;
  int             recv_idle_pct = 0;
  int             hold_left = 0;
  logic [31:0]    ms_now = '0;
  logic [31:0]    hash_pool [POOL_SIZE];

  recent_device_report_filter_unit #(
    .ENTRIES(ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .obs      (obs),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .res      (res),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // result side: long hold-off on request, otherwise random stalls
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // compare each accepted result word with the oldest prediction
  always @(posedge clk) begin
    rdrf_pkg::res_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_res.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: report=%0d outcome=%0d slot=%0d",
                   res.report, res.outcome, res.slot);
      end else begin
        want = expected_res.pop_front();
        if (res.report !== want.report || res.outcome !== want.outcome ||
            res.slot !== want.slot) begin
          mismatches++;
          if (mismatches <= MAX_SHOWN)
            $display({"mismatch: want report=%0d outcome=%0d slot=%0d, ",
                      "got report=%0d outcome=%0d slot=%0d"},
                     want.report, want.outcome, want.slot,
                     res.report, res.outcome, res.slot);
        end
      end
    end
  end

  task automatic clear_shadow();
    for (int i = 0; i < ENTRIES; i++) begin
      tab_hash[i] = '0;
      tab_seen[i] = '0;
    end
    rssi_floor = rdrf_pkg::MIN_RSSI_RST;
    repeat_ms = rdrf_pkg::REPEAT_RST;
  endtask

  // filter decision for one observation; updates the shadow table
  function automatic rdrf_pkg::res_t judge_observation(rdrf_pkg::obs_t o);
    rdrf_pkg::res_t r;
    logic [31:0]    age;
    int             free_idx;
    int             oldest;
    r = '0;
    free_idx = -1;
    oldest = 0;
    if ($signed(o.signal_dbm) < rssi_floor) begin
      r.outcome = rdrf_pkg::OUT_WEAK;
      return r;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (tab_hash[i] == o.device_hash) begin
        age = o.now_ms - tab_seen[i];
        r.slot = rdrf_pkg::SLOT_W'(i);
        if (age < repeat_ms) begin
          r.outcome = rdrf_pkg::OUT_RECENT;
        end else begin
          tab_seen[i] = o.now_ms;
          r.report = 1'b1;
          r.outcome = rdrf_pkg::OUT_REFRESH;
        end
        return r;
      end
      if (tab_hash[i] == '0 && free_idx < 0)
        free_idx = i;
      // plain unsigned compare, lowest index wins ties
      if (tab_seen[i] < tab_seen[oldest])
        oldest = i;
    end
    r.report = 1'b1;
    if (free_idx >= 0) begin
      r.outcome = rdrf_pkg::OUT_FILLED;
    end else begin
      free_idx = oldest;
      r.outcome = rdrf_pkg::OUT_REPLACED;
    end
    tab_hash[free_idx] = o.device_hash;
    tab_seen[free_idx] = o.now_ms;
    r.slot = rdrf_pkg::SLOT_W'(free_idx);
    return r;
  endfunction

  function automatic rdrf_pkg::obs_t mk(logic [31:0] h, logic signed [7:0] s,
                                        logic [31:0] t);
    rdrf_pkg::obs_t o;
    o.device_hash = h;
    o.signal_dbm = s;
    o.now_ms = t;
    return o;
  endfunction

  // send one observation word; valid stays up until accepted
  task automatic offer_obs(rdrf_pkg::obs_t o);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    obs <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    expected_res.push_back(judge_observation(o));
  endtask

  // stop sending and let every pending result come back
  task automatic wait_drained();
    if (expected_res.size() != 0) begin
      in_valid <= 1'b0;
      while (expected_res.size() != 0) @(posedge clk);
    end
  endtask

  task automatic cfg_beat(logic [rdrf_pkg::CFG_IDX_W-1:0] idx,
                          logic [rdrf_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      rdrf_pkg::REG_MIN_RSSI: rssi_floor = data[7:0];
      rdrf_pkg::REG_REPEAT:   repeat_ms = data;
      default: ;
    endcase
  endtask

  // write both registers while the block is idle; upper data bits are junk
  task automatic set_config(logic signed [7:0] floor_dbm, logic [31:0] interval,
                            bit with_spare);
    logic [31:0] word;
    wait_drained();
    if (with_spare)
      cfg_beat($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom);
    word = $urandom;
    word[7:0] = floor_dbm;
    cfg_beat(rdrf_pkg::REG_MIN_RSSI, word);
    cfg_beat(rdrf_pkg::REG_REPEAT, interval);
    cfg_valid <= 1'b0;
  endtask

  function automatic rdrf_pkg::obs_t random_obs();
    rdrf_pkg::obs_t o;
    int unsigned    pick;
    pick = $urandom_range(99);
    if (pick < 75)
      o.device_hash = hash_pool[$urandom_range(POOL_SIZE - 1)];
    else if (pick < 82)
      o.device_hash = '0;
    else
      o.device_hash = $urandom;
    pick = $urandom_range(99);
    if (pick < 10)
      o.signal_dbm = rssi_floor;
    else if (pick < 15)
      o.signal_dbm = rssi_floor - 8'sd1;
    else
      o.signal_dbm = 8'($urandom);
    // mostly small time steps so repeats land on both sides of the interval
    pick = $urandom_range(99);
    if (pick < 85)
      ms_now += $urandom_range(3000);
    else if (pick < 95)
      ms_now += $urandom_range(20000);
    else
      ms_now += $urandom;
    o.now_ms = ms_now;
    return o;
  endfunction

  // reset defaults: threshold edge, repeat window, zero hash, time wrap
  task automatic test_directed_cases();
    offer_obs(mk(32'h1234_5678, -8'sd91, 32'd100));
    offer_obs(mk(32'h1234_5678, -8'sd90, 32'd100));
    offer_obs(mk(32'h1234_5678, 8'sd127, 32'd5000));
    offer_obs(mk(32'h1234_5678, -8'sd128, 32'd6000));
    offer_obs(mk(32'h1234_5678, 8'sd0, 32'd10100));
    offer_obs(mk(32'h0, 8'sd0, 32'd50));
    offer_obs(mk(32'h0, 8'sd0, 32'd20000));
    offer_obs(mk(32'hFFFF_FFFF, 8'sd127, 32'hFFFF_FFFF));
    offer_obs(mk(32'hFFFF_FFFF, 8'sd1, 32'd5));
    offer_obs(mk(32'h8000_0000, -8'sd1, 32'h8000_0000));
  endtask

  // full table with tied timestamps, then misses pick the oldest entry
  task automatic test_oldest_choice();
    set_config(-8'sd128, 32'd0, 1'b1);
    for (int i = 0; i < ENTRIES - 3; i++)
      offer_obs(mk(32'hA000_0000 + i, 8'sd0, 32'd7));
    offer_obs(mk(32'hB000_0001, 8'sd5, 32'd7));
    offer_obs(mk(32'h1234_5678, 8'sd5, 32'd10100));
    offer_obs(mk(32'h0, 8'sd5, 32'd8));
    offer_obs(mk(32'hC000_0000, 8'sd5, 32'd9));
  endtask

  // highest threshold and longest interval
  task automatic test_extreme_config();
    set_config(8'sd127, 32'hFFFF_FFFF, 1'b0);
    offer_obs(mk(32'hB000_0001, 8'sd126, 32'd100));
    offer_obs(mk(32'hB000_0001, 8'sd127, 32'd6));
    offer_obs(mk(32'hB000_0001, 8'sd127, 32'd100));
    offer_obs(mk(32'hD000_0000, 8'sd127, 32'd200));
  endtask

  task automatic test_random_phase(int count, int s_pct, int r_pct);
    int sent;
    int group;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < POOL_SIZE; i++)
      hash_pool[i] = $urandom;
    hash_pool[0] = 32'hFFFF_FFFF;
    hash_pool[1] = 32'h0000_0001;
    ms_now = $urandom;
    sent = 0;
    while (sent < count) begin
      group = $urandom_range(20, 60);
      case ($urandom_range(5))
        0: set_config(rdrf_pkg::MIN_RSSI_RST, rdrf_pkg::REPEAT_RST,
                      $urandom_range(3) == 0);
        1: set_config(-8'sd128, 32'd0, $urandom_range(3) == 0);
        2: begin
          set_config(8'sd127, 32'hFFFF_FFFF, $urandom_range(3) == 0);
          group = 5;
        end
        3: set_config(-8'sd100 + 8'($urandom_range(80)), $urandom_range(8000),
                      $urandom_range(3) == 0);
        4: set_config(8'($urandom), $urandom, $urandom_range(3) == 0);
        default: set_config(-8'sd70, 32'd1, $urandom_range(3) == 0);
      endcase
      for (int i = 0; i < group; i++) begin
        offer_obs(random_obs());
        // occasional sender pause until the block is empty
        if ($urandom_range(39) == 0)
          wait_drained();
      end
      sent += group;
    end
  endtask

  // receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    set_config(-8'sd128, 32'd500, 1'b0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left = 300;
    for (int i = 0; i < 16; i++)
      offer_obs(random_obs());
    wait_drained();
  endtask

  initial begin
    clear_shadow();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_cases();
    test_oldest_choice();
    test_extreme_config();
    test_random_phase(190, 33, 79);
    test_random_phase(190, 79, 33);
    test_random_phase(190, 0, 0);
    test_backpressure();
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/rdrf_pkg.sv
src/rdrf_cell.sv
src/recent_device_report_filter_unit.sv
tb/tb.sv
